### rtl/spa_pkg.sv
// Shared types, constants and the arctangent step table for the sprite affine setup.
package spa_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_TAB_LEN  = 24;
  localparam int CORDIC_N      = (CORDIC_STAGES > ATAN_TAB_LEN) ? ATAN_TAB_LEN : CORDIC_STAGES;
  localparam int STAGE_IDX_W   = 5;

  // Reciprocal of the CORDIC gain of CORDIC_N stages in Q1.30
  localparam longint GAIN_Q30 = 64'd652032875 + (64'd434688583 >> (2 * CORDIC_N));

  localparam int CORD_W    = 34;
  localparam int SIZE_W    = 31;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_SIZE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_HEIGHT = 1'b1;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [15:0] scale_x;
    logic signed [15:0] scale_y;
    logic        [15:0] angle;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] coef_a;
    logic signed [23:0] coef_b;
    logic signed [23:0] coef_c;
    logic signed [23:0] coef_d;
    logic signed [31:0] shift_x;
    logic signed [31:0] shift_y;
    logic signed [31:0] box_width;
    logic signed [31:0] box_height;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [15:0] scale_x;
    logic signed [15:0] scale_y;
    logic        [1:0]  quad;
  } side_t;

  typedef struct packed {
    logic               valid;
    logic signed [CORD_W-1:0] x;
    logic signed [CORD_W-1:0] y;
    logic signed [CORD_W-1:0] z;
    side_t              side;
  } cord_t;

  typedef struct packed {
    logic               valid;
    logic signed [23:0] a;
    logic signed [23:0] b;
    logic signed [23:0] c;
    logic signed [23:0] d;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
  } coef_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } res_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [31:0] atan_turn(input logic [STAGE_IDX_W-1:0] idx);
    logic [31:0] t;
    begin
      case (idx)
        5'd0:    t = 32'd536870912;
        5'd1:    t = 32'd316933406;
        5'd2:    t = 32'd167458907;
        5'd3:    t = 32'd85004756;
        5'd4:    t = 32'd42667331;
        5'd5:    t = 32'd21354465;
        5'd6:    t = 32'd10679838;
        5'd7:    t = 32'd5340245;
        5'd8:    t = 32'd2670163;
        5'd9:    t = 32'd1335087;
        5'd10:   t = 32'd667544;
        5'd11:   t = 32'd333772;
        5'd12:   t = 32'd166886;
        5'd13:   t = 32'd83443;
        5'd14:   t = 32'd41722;
        5'd15:   t = 32'd20861;
        5'd16:   t = 32'd10430;
        5'd17:   t = 32'd5215;
        5'd18:   t = 32'd2608;
        5'd19:   t = 32'd1304;
        5'd20:   t = 32'd652;
        5'd21:   t = 32'd326;
        5'd22:   t = 32'd163;
        5'd23:   t = 32'd81;
        default: t = 32'd0;
      endcase
      atan_turn = t;
    end
  endfunction

endpackage

### rtl/spa_cordic_cell.sv
// One rotation-mode CORDIC cell: a micro-rotation and its pipeline register.
module spa_cordic_cell (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic [spa_pkg::STAGE_IDX_W-1:0]  stage_idx,
  input  spa_pkg::cord_t                   cell_in,
  output spa_pkg::cord_t                   cell_out
);

  spa_pkg::cord_t cell_r;
  spa_pkg::cord_t cell_nxt;
  logic signed [spa_pkg::CORD_W-1:0] dx;
  logic signed [spa_pkg::CORD_W-1:0] dy;
  logic signed [spa_pkg::CORD_W-1:0] step;

  always_comb begin
    dx       = cell_in.y >>> stage_idx;
    dy       = cell_in.x >>> stage_idx;
    step     = spa_pkg::CORD_W'(spa_pkg::atan_turn(stage_idx));
    cell_nxt = cell_in;
    // rotate toward zero residual angle
    if (!cell_in.z[spa_pkg::CORD_W-1]) begin
      cell_nxt.x = cell_in.x - dx;
      cell_nxt.y = cell_in.y + dy;
      cell_nxt.z = cell_in.z - step;
    end else begin
      cell_nxt.x = cell_in.x + dx;
      cell_nxt.y = cell_in.y - dy;
      cell_nxt.z = cell_in.z + step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.valid <= 1'b0;
    end else if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign cell_out = cell_r;

endmodule

### rtl/spa_coef.sv
// Quadrant unfold, scale products, rounding and saturation of the four matrix coefficients.
module spa_coef (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  spa_pkg::cord_t  cord_in,
  output spa_pkg::coef_t  coef_out
);

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;
  localparam logic signed [50:0] RND = 51'sd2097152;

  function automatic logic signed [23:0] sat24(input logic signed [28:0] v);
    begin
      if (v > 29'sd8388607)       sat24 = 24'sh7F_FFFF;
      else if (v < -29'sd8388608) sat24 = 24'sh80_0000;
      else                        sat24 = v[23:0];
    end
  endfunction

  // stage 1: cos / sin
  logic                              v1_r;
  logic signed [spa_pkg::CORD_W-1:0] cs_r, sn_r, nsn_r;
  logic signed [spa_pkg::CORD_W-1:0] cs_nxt, sn_nxt;
  spa_pkg::side_t                    side1_r;

  // stage 2: products
  logic                v2_r;
  logic signed [49:0]  pa_r, pb_r, pc_r, pd_r;
  spa_pkg::side_t      side2_r;

  // stage 3: rounded coefficients
  spa_pkg::coef_t      coef_r;
  logic signed [50:0]  ra, rb, rc, rd;
  logic signed [50:0]  sa, sb, sc, sd;

  always_comb begin
    case (cord_in.side.quad)
      QUAD_0:  begin cs_nxt = cord_in.x;  sn_nxt = cord_in.y;  end
      QUAD_1:  begin cs_nxt = -cord_in.y; sn_nxt = cord_in.x;  end
      QUAD_2:  begin cs_nxt = -cord_in.x; sn_nxt = -cord_in.y; end
      QUAD_3:  begin cs_nxt = cord_in.y;  sn_nxt = -cord_in.x; end
      default: begin cs_nxt = cord_in.x;  sn_nxt = cord_in.y;  end
    endcase
  end

  always_comb begin
    ra = pa_r + RND;
    rb = pb_r + RND;
    rc = pc_r + RND;
    rd = pd_r + RND;
    sa = ra >>> 22;
    sb = rb >>> 22;
    sc = rc >>> 22;
    sd = rd >>> 22;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      coef_r.valid <= 1'b0;
    end else if (en) begin
      v1_r         <= cord_in.valid;
      v2_r         <= v1_r;
      coef_r.valid <= v2_r;
    end
    if (en) begin
      cs_r    <= cs_nxt;
      sn_r    <= sn_nxt;
      nsn_r   <= -sn_nxt;
      side1_r <= cord_in.side;

      pa_r    <= side1_r.scale_x * cs_r;
      pb_r    <= side1_r.scale_y * nsn_r;
      pc_r    <= side1_r.scale_x * sn_r;
      pd_r    <= side1_r.scale_y * cs_r;
      side2_r <= side1_r;

      coef_r.a        <= sat24(sa[28:0]);
      coef_r.b        <= sat24(sb[28:0]);
      coef_r.c        <= sat24(sc[28:0]);
      coef_r.d        <= sat24(sd[28:0]);
      coef_r.pos_x    <= side2_r.pos_x;
      coef_r.pos_y    <= side2_r.pos_y;
      coef_r.origin_x <= side2_r.origin_x;
      coef_r.origin_y <= side2_r.origin_y;
    end
  end

  assign coef_out = coef_r;

endmodule

### rtl/spa_xform.sv
// Translation and box extent: origin and size products, sums, rounding and saturation.
module spa_xform (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  spa_pkg::coef_t                coef_in,
  input  logic [spa_pkg::SIZE_W-1:0]    size_w,
  input  logic [spa_pkg::SIZE_W-1:0]    size_h,
  output spa_pkg::res_t                 res_out
);

  localparam int SUM_W = 58;
  localparam logic signed [SUM_W-1:0] HALF = 58'sd32768;

  function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
    begin
      if (v > 42'sd2147483647)       sat32 = 32'sh7FFF_FFFF;
      else if (v < -42'sd2147483648) sat32 = 32'sh8000_0000;
      else                           sat32 = v[31:0];
    end
  endfunction

  logic signed [31:0] ws, hs;

  // stage 1: products
  logic               v1_r;
  logic signed [55:0] m_aox_r, m_boy_r, m_cox_r, m_doy_r;
  logic signed [55:0] m_aw_r, m_bh_r, m_cw_r, m_dh_r;
  logic signed [23:0] a1_r, b1_r, c1_r, d1_r;
  logic signed [31:0] px1_r, py1_r;

  // stage 2: sums
  logic                   v2_r;
  logic signed [SUM_W-1:0] tx_r, ty_r, bw_r, bh_r;
  logic signed [SUM_W-1:0] tx_nxt, ty_nxt, bw_nxt, bh_nxt;
  logic signed [23:0]     a2_r, b2_r, c2_r, d2_r;
  logic signed [SUM_W-1:0] stx, sty, sbw, sbh;

  spa_pkg::res_t res_r;

  assign ws = $signed({1'b0, size_w});
  assign hs = $signed({1'b0, size_h});

  always_comb begin
    tx_nxt = (SUM_W'(px1_r) <<< 16) - (SUM_W'(m_aox_r) + SUM_W'(m_boy_r)) + HALF;
    ty_nxt = (SUM_W'(py1_r) <<< 16) - (SUM_W'(m_cox_r) + SUM_W'(m_doy_r)) + HALF;
    bw_nxt = SUM_W'(m_aw_r) + SUM_W'(m_bh_r) + HALF;
    bh_nxt = SUM_W'(m_cw_r) + SUM_W'(m_dh_r) + HALF;
    stx    = tx_r >>> 16;
    sty    = ty_r >>> 16;
    sbw    = bw_r >>> 16;
    sbh    = bh_r >>> 16;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      res_r.valid <= 1'b0;
    end else if (en) begin
      v1_r        <= coef_in.valid;
      v2_r        <= v1_r;
      res_r.valid <= v2_r;
    end
    if (en) begin
      m_aox_r <= coef_in.a * coef_in.origin_x;
      m_boy_r <= coef_in.b * coef_in.origin_y;
      m_cox_r <= coef_in.c * coef_in.origin_x;
      m_doy_r <= coef_in.d * coef_in.origin_y;
      m_aw_r  <= coef_in.a * ws;
      m_bh_r  <= coef_in.b * hs;
      m_cw_r  <= coef_in.c * ws;
      m_dh_r  <= coef_in.d * hs;
      a1_r    <= coef_in.a;
      b1_r    <= coef_in.b;
      c1_r    <= coef_in.c;
      d1_r    <= coef_in.d;
      px1_r   <= coef_in.pos_x;
      py1_r   <= coef_in.pos_y;

      tx_r <= tx_nxt;
      ty_r <= ty_nxt;
      bw_r <= bw_nxt;
      bh_r <= bh_nxt;
      a2_r <= a1_r;
      b2_r <= b1_r;
      c2_r <= c1_r;
      d2_r <= d1_r;

      res_r.item.coef_a     <= a2_r;
      res_r.item.coef_b     <= b2_r;
      res_r.item.coef_c     <= c2_r;
      res_r.item.coef_d     <= d2_r;
      res_r.item.shift_x    <= sat32(stx[41:0]);
      res_r.item.shift_y    <= sat32(sty[41:0]);
      res_r.item.box_width  <= sat32(sbw[41:0]);
      res_r.item.box_height <= sat32(sbh[41:0]);
    end
  end

  assign res_out = res_r;

endmodule

### rtl/spa_out_buf.sv
// Output register with one skid entry; its fill state advances or holds the pipeline.
module spa_out_buf (
  input  logic                clk,
  input  logic                rst_n,
  input  spa_pkg::res_t       res_in,
  input  logic                out_stall,
  output logic                out_valid,
  output spa_pkg::out_item_t  out_item,
  output logic                adv
);

  logic               out_v_r, skid_v_r;
  spa_pkg::out_item_t out_d_r, skid_d_r;
  logic               push, pop;

  assign adv  = !skid_v_r;
  assign push = res_in.valid && adv;
  assign pop  = out_v_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (pop) begin
        out_d_r  <= skid_d_r;
        skid_v_r <= 1'b0;
      end
    end else if (push) begin
      if (!out_v_r || pop) begin
        out_d_r <= res_in.item;
        out_v_r <= 1'b1;
      end else begin
        skid_d_r <= res_in.item;
        skid_v_r <= 1'b1;
      end
    end else if (pop) begin
      out_v_r <= 1'b0;
    end
  end

  assign out_valid = out_v_r;
  assign out_item  = out_d_r;

endmodule

### rtl/sprite_affine_setup.sv
// Sprite affine setup top level: CORDIC cell chain, coefficient and translation stages.
//
// Takes one sprite request (position, pivot origin, Q8.8 scales and a 16-bit
// angle in turns/65536) per cycle unless stalled, and returns the affine matrix
// translate*rotate*scale*(-origin) as Q8.16 coefficients a, b, c, d, the Q16.16
// translation (also the box lower-left corner) and the box extent M*(w,h) for
// the sprite size held in the size_width / size_height registers. Every output
// saturates to its width. The pipeline accepts a new request every cycle while
// in_stall is low. Each result passes through the CORDIC cells, the coefficient
// stage (quadrant unfold, scale multiply, round), the translation stage
// (products, sums, round and saturate) and the output register, in that order.
// The whole pipeline advances together and holds only once both the output
// register and its skid entry are full, so in_stall is a registered signal.
// Write the size registers only while no request is in flight.
module sprite_affine_setup (
  input  logic                            clk,
  input  logic                            rst_n,

  input  logic                            in_valid,
  output logic                            in_stall,
  input  spa_pkg::in_item_t               in_item,

  output logic                            out_valid,
  input  logic                            out_stall,
  output spa_pkg::out_item_t              out_item,

  input  logic                            cfg_we,
  input  logic [spa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [spa_pkg::SIZE_W-1:0]      cfg_wdata
);

  logic [spa_pkg::SIZE_W-1:0] size_w_r, size_h_r;
  logic                       adv;

  // angle reduction
  logic [15:0]        ang_sh;
  logic signed [13:0] resid;

  spa_pkg::cord_t cord_head;
  spa_pkg::cord_t chain [spa_pkg::CORDIC_N+1];
  spa_pkg::coef_t coef;
  spa_pkg::res_t  res;

  // size registers: ignore writes to unknown indexes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_w_r <= '0;
      size_h_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        spa_pkg::REG_SIZE_WIDTH:  size_w_r <= cfg_wdata;
        spa_pkg::REG_SIZE_HEIGHT: size_h_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Offset by an eighth turn so the quadrant comes from the top two bits and
  // the residual lands in [-1/8, 1/8) turn, then scale it to 2^-32 turn.
  always_comb begin
    ang_sh                   = in_item.angle + 16'h2000;
    resid                    = $signed({~ang_sh[13], ang_sh[12:0]});
    cord_head.valid          = in_valid;
    cord_head.x              = spa_pkg::CORD_W'(spa_pkg::GAIN_Q30);
    cord_head.y              = '0;
    cord_head.z              = spa_pkg::CORD_W'(resid) <<< 16;
    cord_head.side.pos_x     = in_item.pos_x;
    cord_head.side.pos_y     = in_item.pos_y;
    cord_head.side.origin_x  = in_item.origin_x;
    cord_head.side.origin_y  = in_item.origin_y;
    cord_head.side.scale_x   = in_item.scale_x;
    cord_head.side.scale_y   = in_item.scale_y;
    cord_head.side.quad      = ang_sh[15:14];
  end

  assign chain[0] = cord_head;

  // CORDIC chain: each cell takes one micro-rotation and hands its vector on
  for (genvar i = 0; i < spa_pkg::CORDIC_N; i++) begin : g_cell
    spa_cordic_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (adv),
      .stage_idx (spa_pkg::STAGE_IDX_W'(i)),
      .cell_in   (chain[i]),
      .cell_out  (chain[i+1])
    );
  end

  spa_coef u_coef (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .cord_in  (chain[spa_pkg::CORDIC_N]),
    .coef_out (coef)
  );

  spa_xform u_xform (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .coef_in (coef),
    .size_w  (size_w_r),
    .size_h  (size_h_r),
    .res_out (res)
  );

  // hold the whole pipeline only while the skid entry is occupied
  spa_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_in    (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_item  (out_item),
    .adv       (adv)
  );

  assign in_stall = !adv;

endmodule

### rtl/spa_checker.sv
// Port-level checks on the sprite affine setup, bound to its top level.
module spa_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input spa_pkg::out_item_t  out_item
);

  logic [7:0] inflight_r;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else begin
      inflight_r <= inflight_r + 8'(in_acc) - 8'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> inflight_r != 8'd0)
    else $error("result delivered with no request in flight");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("reset did not clear the output side");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("input stalled without a blocked result");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled while output register empty");

endmodule

bind sprite_affine_setup spa_checker u_spa_checker (.*);
